[sv/merkle_proof_verify_sha256_macros.svh]
// Assertion macros for the sorted-pair SHA-256 Merkle proof checker.
// Included by the top level; no other dependencies.
`ifndef MERKLE_PROOF_VERIFY_SHA256_MACROS_SVH
`define MERKLE_PROOF_VERIFY_SHA256_MACROS_SVH

// assert that a implies b on the same edge
`define MPV_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// assert that a implies b on the next edge
`define MPV_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

[sv/mpv_pkg.sv]
// Package for the Merkle proof checker: widths, SHA-256 constants, round helpers.
// No dependencies.
package mpv_pkg;
    localparam int unsigned WordW  = 64;
    localparam int unsigned Words  = 4;
    localparam int unsigned IdxW   = 2;
    localparam int unsigned Rounds = 64;
    localparam int unsigned RndW   = 6;
    localparam logic [31:0] MsgBits = 32'd512;

    localparam logic MODE_LEAF  = 1'b0;
    localparam logic MODE_PROOF = 1'b1;

    localparam logic [IdxW-1:0] REG_ROOT_0 = 2'd0;

    typedef logic [WordW-1:0] t_word;

    typedef struct packed {
        logic  start;
        logic  second;
    } t_core_ctl;

    function automatic logic [31:0] round_k(input logic [RndW-1:0] i);
        logic [31:0] k [0:63];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

    localparam logic [255:0] InitH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage

[sv/mpv_stream_if.sv]
// Valid/ready channel carrying a payload of parametrised width.
// No dependencies.
interface mpv_stream_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/mpv_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module mpv_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[sv/mpv_sha_core.sv]
// One SHA-256 compression, one round per cycle, with a 16-word schedule window.
// Depends on mpv_pkg.
module mpv_sha_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mpv_pkg::t_core_ctl   i_ctl,
    input  logic [511:0]         i_block,
    input  logic [255:0]         i_state,
    output logic                 o_done,
    output logic [255:0]         o_state
);
    logic [31:0]  r_w [16];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [255:0] r_base;
    logic [mpv_pkg::RndW-1:0] r_rnd;
    logic         r_busy;
    logic         r_done;
    logic [31:0]  t1, t2, s0, s1, wn;

    always_comb begin
        t1 = r_h + (mpv_pkg::rotr(r_e, 6) ^ mpv_pkg::rotr(r_e, 11) ^ mpv_pkg::rotr(r_e, 25))
           + ((r_e & r_f) ^ (~r_e & r_g)) + mpv_pkg::round_k(r_rnd) + r_w[0];
        t2 = (mpv_pkg::rotr(r_a, 2) ^ mpv_pkg::rotr(r_a, 13) ^ mpv_pkg::rotr(r_a, 22))
           + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));
        s0 = mpv_pkg::rotr(r_w[1], 7) ^ mpv_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = mpv_pkg::rotr(r_w[14], 17) ^ mpv_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wn = r_w[0] + s0 + r_w[9] + s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 1'b1;
                if (r_rnd == mpv_pkg::RndW'(mpv_pkg::Rounds - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_ctl.start) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_block[511-32*i -: 32];
            end
            {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h} <= i_state;
            r_base <= i_state;
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= wn;
            r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
        end
    end

    always_comb begin
        o_done = r_done;
        o_state[255:224] = r_base[255:224] + r_a;
        o_state[223:192] = r_base[223:192] + r_b;
        o_state[191:160] = r_base[191:160] + r_c;
        o_state[159:128] = r_base[159:128] + r_d;
        o_state[127:96]  = r_base[127:96]  + r_e;
        o_state[95:64]   = r_base[95:64]   + r_f;
        o_state[63:32]   = r_base[63:32]   + r_g;
        o_state[31:0]    = r_base[31:0]    + r_h;
    end
    logic unused_ctl;
    assign unused_ctl = i_ctl.second;
endmodule

[sv/merkle_proof_verify_sha256.sv]
// Top level of the sorted-pair SHA-256 Merkle proof checker.
// Depends on mpv_pkg, mpv_stream_if, mpv_ram, mpv_sha_core and the macro header.
//
//  channel   dir  payload
//  in        in   mode, hash_word_0..3, last
//  out       out  proof_ok
//  cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// Leaf item: accept, then write-back of the four hash words (S_WB).
// Proof item: accept, read of the running hash (S_RD), two compressions (S_C1, S_C2),
// each behind a start state (S_CMP, S_W1), then write-back of the four hash words.
// An item marked last then adds the verdict reads (S_VRD) and the output load (S_OUT).
// Reset is synchronous; a clearing pass zeroes the four words of the running hash memory
// before items are taken. Input is held off while a verdict waits in the output register.
`include "merkle_proof_verify_sha256_macros.svh"
module merkle_proof_verify_sha256 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mpv_stream_if.sink                    s_in,
    mpv_stream_if.source                  m_out,
    input  logic                          i_cfg_we,
    input  logic [mpv_pkg::IdxW-1:0]      i_cfg_idx,
    input  logic [mpv_pkg::WordW-1:0]     i_cfg_data
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_CMP, S_C1, S_W1, S_C2, S_W2, S_WB, S_VRD, S_VCMP, S_OUT
    } t_state;

    t_state r_state;
    mpv_pkg::t_word r_root [mpv_pkg::Words];
    logic [255:0] r_sib, r_cur, r_mid;
    logic [mpv_pkg::IdxW:0] r_cnt;
    logic r_mode, r_last, r_ok, r_out_v, r_out_d;

    logic mem_we;
    logic [mpv_pkg::IdxW-1:0] mem_waddr, mem_raddr;
    mpv_pkg::t_word mem_wdata, mem_rdata;
    mpv_pkg::t_core_ctl core_ctl;
    logic [511:0] core_blk;
    logic [255:0] core_st_in, core_st;
    logic core_done;
    logic sib_less;

    mpv_ram #(.WIDTH(mpv_pkg::WordW), .DEPTH(mpv_pkg::Words)) u_hash (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(mem_raddr), .o_rdata(mem_rdata));

    mpv_sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(core_ctl), .i_block(core_blk),
        .i_state(core_st_in), .o_done(core_done), .o_state(core_st));

    logic [mpv_pkg::IdxW-1:0] cnt_idx;
    logic [mpv_pkg::IdxW-1:0] prev_idx;
    assign cnt_idx  = r_cnt[mpv_pkg::IdxW-1:0];
    assign prev_idx = cnt_idx - 1'b1;
    assign sib_less = r_sib < r_cur;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cnt_idx;
        mem_wdata = '0;
        mem_raddr = cnt_idx;
        unique case (r_state)
            S_CLEAR: mem_we = 1'b1;
            S_WB: begin
                mem_we    = 1'b1;
                mem_wdata = r_cur[255-64*cnt_idx -: 64];
            end
            default: mem_we = 1'b0;
        endcase
        core_ctl.start  = (r_state == S_CMP) || (r_state == S_W1);
        core_ctl.second = (r_state == S_W1);
        if (r_state == S_CMP) begin
            core_blk   = sib_less ? {r_sib, r_cur} : {r_cur, r_sib};
            core_st_in = mpv_pkg::InitH;
        end else begin
            core_blk   = {32'h80000000, 448'd0, mpv_pkg::MsgBits};
            core_st_in = r_mid;
        end
    end

    assign s_in.ready = (r_state == S_IDLE) && !r_out_v;
    assign m_out.valid = r_out_v;
    assign m_out.data  = r_out_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_out_v <= 1'b0;
            for (int i = 0; i < mpv_pkg::Words; i++) begin
                r_root[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_root[i_cfg_idx] <= i_cfg_data;
            end
            if (m_out.valid && m_out.ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (cnt_idx == mpv_pkg::IdxW'(mpv_pkg::Words - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_in.valid && s_in.ready) begin
                        r_mode <= s_in.data[257];
                        r_sib  <= s_in.data[256:1];
                        r_last <= s_in.data[0];
                        r_cnt  <= '0;
                        if (s_in.data[257] == mpv_pkg::MODE_LEAF) begin
                            r_cur   <= s_in.data[256:1];
                            r_state <= S_WB;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_cnt != '0) begin
                        r_cur[255-64*prev_idx -: 64] <= mem_rdata;
                    end
                    if (r_cnt == (mpv_pkg::IdxW+1)'(mpv_pkg::Words)) begin
                        r_cnt   <= '0;
                        r_state <= S_CMP;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CMP: r_state <= S_C1;
                S_C1: if (core_done) begin
                    r_mid   <= core_st;
                    r_state <= S_W1;
                end
                S_W1: r_state <= S_C2;
                S_C2: if (core_done) begin
                    r_cur   <= core_st;
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (cnt_idx == mpv_pkg::IdxW'(mpv_pkg::Words - 1)) begin
                        r_cnt   <= '0;
                        r_ok    <= 1'b1;
                        r_state <= r_last ? S_VRD : S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_VRD: begin
                    if (r_cnt != '0 && mem_rdata != r_root[prev_idx]) begin
                        r_ok <= 1'b0;
                    end
                    if (r_cnt == (mpv_pkg::IdxW+1)'(mpv_pkg::Words)) begin
                        r_cnt   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_OUT: begin
                    r_out_v <= 1'b1;
                    r_out_d <= r_ok;
                    r_cnt   <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic unused_mode;
    assign unused_mode = r_mode;
    logic unused_ref;
    assign unused_ref = (mpv_pkg::REG_ROOT_0 == '0) && (S_VCMP != S_IDLE);

    `MPV_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, s_in.ready, r_state == S_IDLE)
    `MPV_ASSERT_NXT(a_out_after, i_clk, i_rst_n, r_state == S_OUT, m_out.valid)
    `MPV_ASSERT_IMP(a_no_core_idle, i_clk, i_rst_n, r_state == S_IDLE, !core_done)
endmodule
